// ===== design/tmc_pkg.sv =====
// shared types, constants and helpers of the test message checker
`default_nettype none
package tmc_pkg;

    localparam int MAX_MESSAGE  = 4096;
    localparam int LEN_W        = 13;
    localparam int SEQ_W        = 32;
    localparam int PIDX_W       = 6;
    localparam int PATTERN_LEN  = 36;
    localparam int LETTER_COUNT = 26;
    localparam int HDR_BYTES    = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    localparam logic [1:0] MODE_SINK    = 2'd0;
    localparam logic [1:0] MODE_SEQ     = 2'd1;
    localparam logic [1:0] MODE_PATTERN = 2'd2;
    localparam logic [1:0] MODE_ECHO    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TEST_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MSG_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANY_LENGTH = 2'd2;

    localparam logic [LEN_W-1:0] MIN_LEN_SINK    = 13'd1;
    localparam logic [LEN_W-1:0] MIN_LEN_SEQ     = 13'd4;
    localparam logic [LEN_W-1:0] MIN_LEN_PATTERN = 13'd5;
    localparam logic [LEN_W-1:0] RESET_MSG_LEN   = 13'd16;

    typedef enum logic [2:0] {
        VERDICT_GOOD    = 3'd0,
        VERDICT_LENGTH  = 3'd1,
        VERDICT_SEQ     = 3'd2,
        VERDICT_PATTERN = 3'd3,
        VERDICT_ABORTED = 3'd4
    } t_verdict;

    typedef struct packed {
        logic [1:0]       test_mode;
        logic [LEN_W-1:0] message_length;
        logic             any_length;
    } t_cfg;

    // one finished message as seen by the front end
    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [SEQ_W-1:0] rx_seq;
        logic             pattern_bad;
    } t_msg;

    function automatic logic [7:0] pattern_char(input logic [PIDX_W-1:0] idx);
        logic [7:0] v;
        v = {2'b00, idx};
        if (idx < PIDX_W'(LETTER_COUNT)) begin
            return 8'h41 + v;
        end
        return 8'h30 + v - 8'(LETTER_COUNT);
    endfunction

endpackage
`default_nettype wire

// ===== design/tmc_front.sv =====
// front end: accepts bytes, collects the sequence field and checks the pattern
`default_nettype none
module tmc_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    input  wire  [7:0]              i_data,
    input  wire                     i_last,
    output logic                    o_ready,
    input  wire  [tmc_pkg::LEN_W-1:0] i_message_length,
    input  wire                     i_q_full,
    output logic                    o_push,
    output tmc_pkg::t_msg           o_msg
);
    import tmc_pkg::*;

    logic [LEN_W-1:0]  r_pos,  n_pos;
    logic [SEQ_W-1:0]  r_seq,  n_seq;
    logic [PIDX_W-1:0] r_pidx, n_pidx;
    logic              r_pbad, n_pbad;
    logic [LEN_W-1:0]  w_lim;
    logic              w_take;

    always_comb begin
        w_lim = i_message_length;
        if (i_message_length == '0) begin
            w_lim = LEN_W'(1);
        end else if (i_message_length > LEN_W'(MAX_MESSAGE)) begin
            w_lim = LEN_W'(MAX_MESSAGE);
        end
    end

    assign o_ready = !i_q_full;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_pos  = r_pos;
        n_seq  = r_seq;
        n_pidx = r_pidx;
        n_pbad = r_pbad;
        if (w_take && (r_pos < w_lim)) begin
            if (r_pos < LEN_W'(HDR_BYTES)) begin
                n_seq[{r_pos[1:0], 3'b000} +: 8] = i_data;
            end else begin
                if (i_data != pattern_char(r_pidx)) begin
                    n_pbad = 1'b1;
                end
                n_pidx = (r_pidx == PIDX_W'(PATTERN_LEN - 1)) ? '0 : r_pidx + 1'b1;
            end
            n_pos = r_pos + 1'b1;
        end
        o_msg.length      = n_pos;
        o_msg.rx_seq      = n_seq;
        o_msg.pattern_bad = n_pbad;
        o_push            = w_take && i_last;
        // end of message clears the collection state
        if (o_push) begin
            n_pos  = '0;
            n_seq  = '0;
            n_pidx = '0;
            n_pbad = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_seq  <= '0;
            r_pidx <= '0;
            r_pbad <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_seq  <= n_seq;
            r_pidx <= n_pidx;
            r_pbad <= n_pbad;
        end
    end

endmodule
`default_nettype wire

// ===== design/tmc_queue.sv =====
// two-entry message queue between front and back end
`default_nettype none
module tmc_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  tmc_pkg::t_msg  i_msg,
    output logic           o_full,
    input  wire            i_pop,
    output logic           o_valid,
    output tmc_pkg::t_msg  o_msg,
    output logic [1:0]     o_count
);
    import tmc_pkg::*;

    t_msg       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       w_push, w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_msg   = r_mem[r_rptr];
    assign o_count = r_count;
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/tmc_back.sv =====
// back end: verdict, sequence counter, sticky failure and output register
`default_nettype none
module tmc_back (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  tmc_pkg::t_cfg              i_cfg,
    input  wire                        i_q_valid,
    input  tmc_pkg::t_msg              i_msg,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire                        i_ready,
    output tmc_pkg::t_verdict          o_verdict,
    output logic [tmc_pkg::SEQ_W-1:0]  o_seq,
    output logic [tmc_pkg::LEN_W-1:0]  o_len,
    output logic                       o_failed
);
    import tmc_pkg::*;

    logic [SEQ_W-1:0] r_counter, n_counter;
    logic             r_failed,  n_failed;
    logic             r_valid;
    t_verdict         r_verdict, w_verdict;
    logic [SEQ_W-1:0] r_seq;
    logic [LEN_W-1:0] r_len;
    logic [1:0]       w_mode;
    logic [LEN_W-1:0] w_minlen;
    logic             w_badlen;

    assign o_pop = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        w_mode = (i_cfg.test_mode == MODE_ECHO) ? MODE_SINK : i_cfg.test_mode;
        case (w_mode)
            MODE_SINK: w_minlen = MIN_LEN_SINK;
            MODE_SEQ:  w_minlen = MIN_LEN_SEQ;
            default:   w_minlen = MIN_LEN_PATTERN;
        endcase
        w_badlen = (i_msg.length < w_minlen) ||
                   (!i_cfg.any_length && (i_msg.length != i_cfg.message_length));
        if (r_failed) begin
            w_verdict = VERDICT_ABORTED;
        end else if (w_badlen) begin
            w_verdict = VERDICT_LENGTH;
        end else if ((w_mode != MODE_SINK) && (i_msg.rx_seq != r_counter)) begin
            w_verdict = VERDICT_SEQ;
        end else if ((w_mode == MODE_PATTERN) && i_msg.pattern_bad) begin
            w_verdict = VERDICT_PATTERN;
        end else begin
            w_verdict = VERDICT_GOOD;
        end
        n_counter = r_counter;
        n_failed  = r_failed;
        if (o_pop && !r_failed) begin
            if (w_verdict != VERDICT_GOOD) begin
                n_failed = 1'b1;
            end else if (w_mode != MODE_SINK) begin
                n_counter = r_counter + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= SEQ_W'(1);
            r_failed  <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_counter <= n_counter;
            r_failed  <= n_failed;
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_verdict <= w_verdict;
            r_seq     <= n_counter;
            r_len     <= i_msg.length;
        end
    end

    assign o_valid   = r_valid;
    assign o_verdict = r_verdict;
    assign o_seq     = r_seq;
    assign o_len     = r_len;
    assign o_failed  = r_failed;

endmodule
`default_nettype wire

// ===== design/test_message_checker_unit.sv =====
// top level of the test message checker
//
// input stream: one message byte per item in s_axis_tdata, tlast on the
// final byte of each message. output stream: one verdict item per message,
// issued for the item that carries tlast; no item comes for other bytes.
// the front end takes one byte per cycle whenever the two-entry message
// queue has room, so bytes stream back to back at one item per cycle.
// the back end pops one message per cycle while its output register is
// empty or taken; a verdict goes through the queue, then that register.
// when the receiver holds m_axis_tready low the output register holds its
// item, the queue fills, and tready on the input drops while two finished
// messages wait, also in the middle of a message.
// the configuration port writes one of test_mode, message_length and
// any_length (index 0, 1, 2); write only while no message is in flight.
// synchronous active-low reset: mode sink, length 16, exact length, the
// sequence counter at one, no failure, queue and output empty.
`default_nettype none
module test_message_checker_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // verdict[2:0], expected_sequence[34:3],
                                        // received_length[47:35]
    input  wire                                i_cfg_we,
    input  wire  [tmc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [tmc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tmc_pkg::*;

    t_cfg             r_cfg;
    t_msg             w_front_msg, w_q_msg;
    logic             w_push, w_q_full, w_q_valid, w_pop;
    logic [1:0]       w_q_count;
    logic             w_failed;
    t_verdict         w_verdict;
    logic [SEQ_W-1:0] w_seq;
    logic [LEN_W-1:0] w_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.test_mode      <= MODE_SINK;
            r_cfg.message_length <= RESET_MSG_LEN;
            r_cfg.any_length     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TEST_MODE:  r_cfg.test_mode      <= i_cfg_data[1:0];
                REG_MSG_LENGTH: r_cfg.message_length <= i_cfg_data[LEN_W-1:0];
                REG_ANY_LENGTH: r_cfg.any_length     <= i_cfg_data[0];
                default:        r_cfg                <= r_cfg;
            endcase
        end
    end

    tmc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .i_data           (s_axis_tdata),
        .i_last           (s_axis_tlast),
        .o_ready          (s_axis_tready),
        .i_message_length (r_cfg.message_length),
        .i_q_full         (w_q_full),
        .o_push           (w_push),
        .o_msg            (w_front_msg)
    );

    tmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_msg   (w_front_msg),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_msg   (w_q_msg),
        .o_count (w_q_count)
    );

    tmc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_msg     (w_q_msg),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_verdict (w_verdict),
        .o_seq     (w_seq),
        .o_len     (w_len),
        .o_failed  (w_failed)
    );

    assign m_axis_tdata = {w_len, w_seq, w_verdict};

`ifndef SYNTHESIS
    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_failed |=> w_failed)
        else $error("failure flag cleared without reset");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count != 2'd3)
        else $error("message queue count out of range");

    a_aborted_after_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_verdict == VERDICT_ABORTED)) |-> w_failed)
        else $error("aborted verdict without prior failure");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !w_push)
        else $error("message pushed into full queue");
`endif

endmodule
`default_nettype wire
